@@ src/pswq_pkg.sv @@
// pswq_pkg: shared types and codes for the priority sorted wait queue
// no dependencies; used by pswq_ctrl, pswq_datapath and the top level
package pswq_pkg;

    localparam int ID_FIELD_W   = 8;
    localparam int PRIO_FIELD_W = 8;
    localparam int HEAD_FIELD_W = 8;
    localparam int STATUS_W     = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic capture;
        logic update;
    } t_ctl_cmd;

endpackage

@@ src/priority_sorted_wait_queue.sv @@
// channel   handshake          payload
// in        i_valid / o_stall  i_command, i_thread_id, i_priority_req
// out       o_valid / i_stall  o_not_empty, o_head_thread, o_waiting_count, o_status
//
// each item is first accepted, which registers the per-slot compares, and then
// updated, which shifts the slot row and loads the result register
// a result held by i_stall delays the update cycle; the next item is accepted
// once the update is done, even while that result still waits
// synchronous reset empties the queue; slot contents are not cleared
// top level; depends on pswq_pkg, pswq_ctrl and pswq_datapath
module priority_sorted_wait_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8,
    parameter int PRIO_BITS   = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_command,
    input  logic [pswq_pkg::ID_FIELD_W-1:0]        i_thread_id,
    input  logic [pswq_pkg::PRIO_FIELD_W-1:0]      i_priority_req,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_not_empty,
    output logic [pswq_pkg::HEAD_FIELD_W-1:0]      o_head_thread,
    output logic [$clog2(QUEUE_DEPTH + 1)-1:0]     o_waiting_count,
    output logic [pswq_pkg::STATUS_W-1:0]          o_status
);

    pswq_pkg::t_ctl_cmd w_cmd;

    pswq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd)
    );

    pswq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS),
        .PRIO_BITS   (PRIO_BITS),
        .CNT_W       ($clog2(QUEUE_DEPTH + 1))
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_command       (i_command),
        .i_thread_id     (i_thread_id),
        .i_priority_req  (i_priority_req),
        .o_not_empty     (o_not_empty),
        .o_head_thread   (o_head_thread),
        .o_waiting_count (o_waiting_count),
        .o_status        (o_status)
    );

endmodule

@@ src/pswq_ctrl.sv @@
// pswq_ctrl: state machine sequencing capture and update of the queue
// depends on pswq_pkg; drives pswq_datapath through t_ctl_cmd
module pswq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    output pswq_pkg::t_ctl_cmd o_cmd
);

    pswq_pkg::t_state r_state;
    pswq_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pswq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.update  = 1'b0;
        o_stall       = 1'b1;
        case (r_state)
            pswq_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = pswq_pkg::S_UPDATE;
                end
            end
            pswq_pkg::S_UPDATE: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.update = 1'b1;
                    n_state      = pswq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pswq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.update) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_valid = r_out_valid;

    a_update_needs_free_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |-> !(r_out_valid && i_stall))
        else $error("update while result register still held");

    a_capture_then_update_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == pswq_pkg::S_UPDATE) && o_stall)
        else $error("capture did not lead to update state");

    a_update_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |=> o_valid)
        else $error("update did not produce a result");

endmodule

@@ src/pswq_datapath.sv @@
// pswq_datapath: slot registers, parallel compares, shift update, result register
// depends on pswq_pkg; controlled by pswq_ctrl through t_ctl_cmd
module pswq_datapath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8,
    parameter int PRIO_BITS   = 8,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pswq_pkg::t_ctl_cmd                    i_cmd,
    input  logic                                  i_command,
    input  logic [pswq_pkg::ID_FIELD_W-1:0]       i_thread_id,
    input  logic [pswq_pkg::PRIO_FIELD_W-1:0]     i_priority_req,
    output logic                                  o_not_empty,
    output logic [pswq_pkg::HEAD_FIELD_W-1:0]     o_head_thread,
    output logic [CNT_W-1:0]                      o_waiting_count,
    output logic [pswq_pkg::STATUS_W-1:0]         o_status
);

    logic [ID_BITS-1:0]   r_thread [QUEUE_DEPTH];
    logic [PRIO_BITS-1:0] r_prio   [QUEUE_DEPTH];
    logic [ID_BITS-1:0]   n_thread [QUEUE_DEPTH];
    logic [PRIO_BITS-1:0] n_prio   [QUEUE_DEPTH];
    logic [CNT_W-1:0]     r_occ;
    logic [CNT_W-1:0]     n_occ;

    logic                 r_cmd;
    logic [ID_BITS-1:0]   r_id;
    logic [PRIO_BITS-1:0] r_new_prio;
    logic                 r_full;
    logic [QUEUE_DEPTH-1:0] r_le;
    logic [QUEUE_DEPTH-1:0] r_eq;

    logic [ID_BITS-1:0]     w_id;
    logic [PRIO_BITS-1:0]   w_prio;
    logic [QUEUE_DEPTH-1:0] w_le;
    logic [QUEUE_DEPTH-1:0] w_eq;
    logic [QUEUE_DEPTH-1:0] w_after;
    logic                   w_found;
    logic [pswq_pkg::STATUS_W-1:0]     n_status;
    logic [pswq_pkg::HEAD_FIELD_W-1:0] n_head;

    logic                              r_not_empty;
    logic [pswq_pkg::HEAD_FIELD_W-1:0] r_head;
    logic [CNT_W-1:0]                  r_count;
    logic [pswq_pkg::STATUS_W-1:0]     r_status;

    // field bits above the stored widths are ignored
    always_comb begin
        w_id   = '0;
        w_prio = '0;
        for (int b = 0; b < ID_BITS && b < pswq_pkg::ID_FIELD_W; b++) begin
            w_id[b] = i_thread_id[b];
        end
        for (int b = 0; b < PRIO_BITS && b < pswq_pkg::PRIO_FIELD_W; b++) begin
            w_prio[b] = i_priority_req[b];
        end
    end

    // per-slot compares against the incoming item
    always_comb begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            w_le[k] = (CNT_W'(k) < r_occ) && (r_prio[k] <= w_prio);
            w_eq[k] = (CNT_W'(k) < r_occ) && (r_thread[k] == w_id);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd      <= i_command;
            r_id       <= w_id;
            r_new_prio <= w_prio;
            r_full     <= (r_occ == CNT_W'(QUEUE_DEPTH));
            r_le       <= w_le;
            r_eq       <= w_eq;
        end
    end

    // slots from the first match upward
    assign w_after = r_eq | (~r_eq + QUEUE_DEPTH'(1));
    assign w_found = w_after[QUEUE_DEPTH-1];

    always_comb begin
        n_thread = r_thread;
        n_prio   = r_prio;
        n_occ    = r_occ;
        n_status = pswq_pkg::ST_DONE;
        case (r_cmd)
            pswq_pkg::CMD_INSERT: begin
                if (r_full) begin
                    n_status = pswq_pkg::ST_FULL;
                end else begin
                    n_occ = r_occ + CNT_W'(1);
                    for (int k = 0; k < QUEUE_DEPTH; k++) begin
                        if (!r_le[k]) begin
                            if (k == 0 || r_le[(k == 0) ? 0 : k - 1]) begin
                                n_thread[k] = r_id;
                                n_prio[k]   = r_new_prio;
                            end else begin
                                n_thread[k] = r_thread[(k == 0) ? 0 : k - 1];
                                n_prio[k]   = r_prio[(k == 0) ? 0 : k - 1];
                            end
                        end
                    end
                end
            end
            pswq_pkg::CMD_REMOVE: begin
                if (!w_found) begin
                    n_status = pswq_pkg::ST_ABSENT;
                end else begin
                    n_occ = r_occ - CNT_W'(1);
                    for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
                        if (w_after[k]) begin
                            n_thread[k] = r_thread[k + 1];
                            n_prio[k]   = r_prio[k + 1];
                        end
                    end
                end
            end
            default: begin
                n_status = pswq_pkg::ST_DONE;
            end
        endcase
    end

    always_comb begin
        n_head = '0;
        if (n_occ != '0) begin
            for (int b = 0; b < ID_BITS && b < pswq_pkg::HEAD_FIELD_W; b++) begin
                n_head[b] = n_thread[0][b];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.update) begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_thread    <= n_thread;
            r_prio      <= n_prio;
            r_not_empty <= (n_occ != '0);
            r_head      <= n_head;
            r_count     <= n_occ;
            r_status    <= n_status;
        end
    end

    assign o_not_empty     = r_not_empty;
    assign o_head_thread   = r_head;
    assign o_waiting_count = r_count;
    assign o_status        = r_status;

    a_occ_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    a_le_is_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> ((r_le & (r_le + QUEUE_DEPTH'(1))) == '0))
        else $error("priority compares not a prefix, queue order broken");

    a_count_tracks_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |=> (o_waiting_count == r_occ))
        else $error("reported count differs from occupancy");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && r_cmd == pswq_pkg::CMD_INSERT && !r_full)
            |=> (r_occ == $past(r_occ) + CNT_W'(1)))
        else $error("accepted insert did not grow the queue");

endmodule
